// ===== hw/rtl/adjugate_inverse_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// adjugate_inverse_3x3_assert
// assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ADJUGATE_INVERSE_3X3_ASSERT_SVH
`define ADJUGATE_INVERSE_3X3_ASSERT_SVH

// same-cycle implication
`define AIV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aiv same-cycle check failed");

// next-cycle implication
`define AIV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aiv next-cycle check failed");

`endif

// ===== hw/rtl/aiv_pkg.sv =====
// ----------------------------------------------------------------------------
// aiv_pkg
// types and widths for the 3x3 adjugate inverse pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package aiv_pkg;

    localparam int ELEM_BITS  = 16;
    localparam int N_ELEM     = 9;
    localparam int PROD_W     = 2 * ELEM_BITS;
    localparam int COF_W      = 2 * ELEM_BITS + 1;
    localparam int CMAG_W     = 2 * ELEM_BITS;
    localparam int DPROD_W    = ELEM_BITS + COF_W;
    localparam int DET_W      = DPROD_W + 2;
    localparam int REM_W      = DET_W + 1;
    localparam int NUM_SHIFT  = 24;
    localparam int QUO_W      = 33;
    localparam int NUM_W      = CMAG_W + NUM_SHIFT;
    localparam int OVF_SHIFT  = QUO_W - NUM_SHIFT;
    localparam int OUT_W      = 32;

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [OUT_W-1:0]     res_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } req_t;

    typedef struct packed {
        res_t b00;
        res_t b01;
        res_t b02;
        res_t b10;
        res_t b11;
        res_t b12;
        res_t b20;
        res_t b21;
        res_t b22;
        logic singular;
    } rsp_t;

    typedef struct packed {
        logic [N_ELEM-1:0][COF_W-1:0] cof;
        logic [2:0][ELEM_BITS-1:0]    top;
    } cof_t;

    typedef struct packed {
        logic [N_ELEM-1:0][REM_W-1:0] rem;
        logic [N_ELEM-1:0][QUO_W-1:0] low;
        logic [N_ELEM-1:0][QUO_W-1:0] quo;
        logic [N_ELEM-1:0]            neg;
        logic [N_ELEM-1:0]            ovf;
        logic [REM_W-1:0]             dmag;
        logic                         singular;
    } div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aiv_cofactor.sv =====
// ----------------------------------------------------------------------------
// aiv_cofactor
// two-stage cofactor unit: products, then differences
// ----------------------------------------------------------------------------
`default_nettype none

module aiv_cofactor (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire aiv_pkg::req_t req,
    output logic               out_valid,
    output aiv_pkg::cof_t      cof
);
    import aiv_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;

    prod_t pa_next [N_ELEM];
    prod_t pb_next [N_ELEM];
    prod_t pa_reg  [N_ELEM];
    prod_t pb_reg  [N_ELEM];
    logic [2:0][ELEM_BITS-1:0] top1_reg;
    logic  v1_reg;
    cof_t  cof_next;
    cof_t  cof_reg;
    logic  v2_reg;

    always_comb
    begin
        pa_next[0] = req.a11 * req.a22;  pb_next[0] = req.a12 * req.a21;
        pa_next[1] = req.a02 * req.a21;  pb_next[1] = req.a01 * req.a22;
        pa_next[2] = req.a01 * req.a12;  pb_next[2] = req.a02 * req.a11;
        pa_next[3] = req.a12 * req.a20;  pb_next[3] = req.a10 * req.a22;
        pa_next[4] = req.a00 * req.a22;  pb_next[4] = req.a02 * req.a20;
        pa_next[5] = req.a02 * req.a10;  pb_next[5] = req.a00 * req.a12;
        pa_next[6] = req.a10 * req.a21;  pb_next[6] = req.a11 * req.a20;
        pa_next[7] = req.a01 * req.a20;  pb_next[7] = req.a00 * req.a21;
        pa_next[8] = req.a00 * req.a11;  pb_next[8] = req.a01 * req.a10;
    end

    always_comb
    begin
        cof_next.top = top1_reg;
        for (int i = 0; i < N_ELEM; i++)
        begin
            cof_next.cof[i] = COF_W'(pa_reg[i]) - COF_W'(pb_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            top1_reg <= {req.a00, req.a01, req.a02};
            cof_reg  <= cof_next;
        end
    end

    assign out_valid = v2_reg;
    assign cof       = cof_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aiv_det.sv =====
// ----------------------------------------------------------------------------
// aiv_det
// determinant, magnitudes and divider setup in four stages
// ----------------------------------------------------------------------------
`default_nettype none

module aiv_det (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire aiv_pkg::cof_t cof,
    output logic               out_valid,
    output aiv_pkg::div_t      div
);
    import aiv_pkg::*;

    typedef logic signed [DPROD_W-1:0] dprod_t;
    typedef logic signed [COF_W-1:0]   scof_t;

    // stage 3: first-row products
    dprod_t dp_next [3];
    dprod_t dp_reg  [3];
    logic [N_ELEM-1:0][COF_W-1:0] c3_reg;
    // stage 4: determinant sum, cofactor magnitudes
    logic signed [DET_W-1:0] det_next;
    logic signed [DET_W-1:0] det_reg;
    logic [N_ELEM-1:0][CMAG_W-1:0] cmag_next;
    logic [N_ELEM-1:0][CMAG_W-1:0] cmag4_reg;
    logic [N_ELEM-1:0]             cneg4_reg;
    // stage 5: determinant magnitude
    logic [REM_W-1:0]              dmag_next;
    logic [REM_W-1:0]              dmag5_reg;
    logic                          dneg5_reg;
    logic                          sing5_reg;
    logic [N_ELEM-1:0][CMAG_W-1:0] cmag5_reg;
    logic [N_ELEM-1:0]             cneg5_reg;
    // stage 6: divider setup
    div_t  div_next;
    div_t  div_reg;
    logic [NUM_W-1:0] num;
    logic [3:0] v_reg;

    always_comb
    begin
        dp_next[0] = $signed(cof.top[2]) * $signed(cof.cof[0]);
        dp_next[1] = $signed(cof.top[1]) * $signed(cof.cof[3]);
        dp_next[2] = $signed(cof.top[0]) * $signed(cof.cof[6]);
    end

    always_comb
    begin
        det_next = DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (c3_reg[i][COF_W-1])
            begin
                cmag_next[i] = CMAG_W'(-$signed(c3_reg[i]));
            end
            else
            begin
                cmag_next[i] = CMAG_W'(c3_reg[i]);
            end
        end
    end

    always_comb
    begin
        if (det_reg[DET_W-1])
        begin
            dmag_next = REM_W'(-det_reg);
        end
        else
        begin
            dmag_next = REM_W'(det_reg);
        end
    end

    always_comb
    begin
        num = '0;
        div_next.dmag     = dmag5_reg;
        div_next.singular = sing5_reg;
        for (int i = 0; i < N_ELEM; i++)
        begin
            num                = {cmag5_reg[i], NUM_SHIFT'(0)};
            div_next.rem[i]    = REM_W'(num[NUM_W-1:QUO_W]);
            div_next.low[i]    = num[QUO_W-1:0];
            div_next.quo[i]    = '0;
            div_next.neg[i]    = cneg5_reg[i] ^ dneg5_reg;
            div_next.ovf[i]    = (REM_W + OVF_SHIFT)'(cmag5_reg[i])
                               >= {dmag5_reg, OVF_SHIFT'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg    <= dp_next;
            c3_reg    <= cof.cof;
            det_reg   <= det_next;
            cmag4_reg <= cmag_next;
            for (int i = 0; i < N_ELEM; i++)
            begin
                cneg4_reg[i] <= c3_reg[i][COF_W-1];
            end
            dmag5_reg <= dmag_next;
            dneg5_reg <= det_reg[DET_W-1];
            sing5_reg <= (det_reg == '0);
            cmag5_reg <= cmag4_reg;
            cneg5_reg <= cneg4_reg;
            div_reg   <= div_next;
        end
    end

    assign out_valid = v_reg[3];
    assign div       = div_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aiv_div_step.sv =====
// ----------------------------------------------------------------------------
// aiv_div_step
// one restoring-division bit for all nine lanes, registered
// ----------------------------------------------------------------------------
`default_nettype none

module aiv_div_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire aiv_pkg::div_t din,
    output logic               out_valid,
    output aiv_pkg::div_t      dout
);
    import aiv_pkg::*;

    div_t div_next;
    div_t div_reg;
    logic valid_reg;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        div_next = din;
        trial    = '0;
        ge       = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            trial = {din.rem[i][REM_W-2:0], din.low[i][QUO_W-1]};
            ge    = (trial >= din.dmag);
            div_next.rem[i] = ge ? (trial - din.dmag) : trial;
            div_next.low[i] = {din.low[i][QUO_W-2:0], 1'b0};
            div_next.quo[i] = {din.quo[i][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = div_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/adjugate_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// adjugate_inverse_3x3
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// ----------------------------------------------------------------------------
// request channel: req_valid / req_stall / req carries one Q8.8 matrix
// response channel: rsp_valid / rsp_stall / rsp carries nine Q16.16
// elements, saturated, plus singular (then all elements are zero)
// stages from request to response: 2 cofactor stages,
// 4 determinant and setup stages, 33 divide stages (one quotient bit per
// stage, nine lanes each) and the output register
// throughput: one request per cycle unless rsp_stall holds the pipeline
// the whole pipeline advances together; while a response waits under
// rsp_stall every stage holds and req_stall is raised, nothing is dropped
// reset clears all valid bits; no other state
// ----------------------------------------------------------------------------
`default_nettype none

module adjugate_inverse_3x3 (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire aiv_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output aiv_pkg::rsp_t      rsp
);
    import aiv_pkg::*;

    `include "adjugate_inverse_3x3_assert.svh"

    logic en;
    logic cof_valid;
    cof_t cof;
    logic det_valid;
    div_t det_div;

    logic [QUO_W:0] stg_valid;
    div_t           stg_div [QUO_W+1];

    res_t res_next [N_ELEM];
    res_t res_reg  [N_ELEM];
    logic sing_reg;
    logic valid_reg;
    div_t dfin;
    logic [QUO_W-1:0] q;

    assign en        = !(valid_reg && rsp_stall);
    assign req_stall = !en;

    aiv_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .req       (req),
        .out_valid (cof_valid),
        .cof       (cof)
    );

    aiv_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_valid),
        .cof       (cof),
        .out_valid (det_valid),
        .div       (det_div)
    );

    assign stg_valid[0] = det_valid;
    assign stg_div[0]   = det_div;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        aiv_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[g]),
            .din       (stg_div[g]),
            .out_valid (stg_valid[g+1]),
            .dout      (stg_div[g+1])
        );
    end

    assign dfin = stg_div[QUO_W];

    always_comb
    begin
        q = '0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            q = dfin.quo[i];
            if (dfin.singular)
            begin
                res_next[i] = '0;
            end
            else if (dfin.neg[i])
            begin
                if (dfin.ovf[i] || q > QUO_W'(33'h0_8000_0000))
                begin
                    res_next[i] = res_t'(32'h8000_0000);
                end
                else
                begin
                    res_next[i] = res_t'(-q[OUT_W-1:0]);
                end
            end
            else
            begin
                if (dfin.ovf[i] || q > QUO_W'(33'h0_7FFF_FFFF))
                begin
                    res_next[i] = res_t'(32'h7FFF_FFFF);
                end
                else
                begin
                    res_next[i] = res_t'(q[OUT_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stg_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            sing_reg <= dfin.singular;
        end
    end

    assign rsp_valid    = valid_reg;
    assign rsp.b00      = res_reg[0];
    assign rsp.b01      = res_reg[1];
    assign rsp.b02      = res_reg[2];
    assign rsp.b10      = res_reg[3];
    assign rsp.b11      = res_reg[4];
    assign rsp.b12      = res_reg[5];
    assign rsp.b20      = res_reg[6];
    assign rsp.b21      = res_reg[7];
    assign rsp.b22      = res_reg[8];
    assign rsp.singular = sing_reg;

    `AIV_ASSERT_IMP(a_stall_only_on_wait, req_stall, rsp_valid && rsp_stall)
    `AIV_ASSERT_IMP(a_singular_zero, rsp_valid && rsp.singular,
        rsp.b00 == 0 && rsp.b11 == 0 && rsp.b22 == 0 && rsp.b02 == 0)
    `AIV_ASSERT_NXT(a_pipe_frozen, req_stall, $stable(stg_valid))

endmodule

`default_nettype wire
